>>> rtl/lifostk_pkg.sv
// ----------------------------------------------------------------------------
// lifostk_pkg
// shared types and constants for the lifo stack with min/max and search
// ----------------------------------------------------------------------------
package lifostk_pkg;

  localparam int DATA_W          = 32;
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 2;
  localparam int FILL_W          = 7;
  localparam int STACK_DEPTH_DEF = 64;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  // control into the shared compare unit
  typedef struct packed {
    logic init;
    logic step;
  } scan_ctl_t;

  // running results of the compare unit
  typedef struct packed {
    logic signed [DATA_W-1:0] max_val;
    logic signed [DATA_W-1:0] min_val;
    logic                     found;
  } scan_res_t;

endpackage

>>> rtl/lifostk_ifs.sv
// ----------------------------------------------------------------------------
// lifostk channel interfaces
// valid/ready channels for operation items and result items
// ----------------------------------------------------------------------------
interface lifostk_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [lifostk_pkg::OP_W-1:0]            operation;
  logic signed [lifostk_pkg::DATA_W-1:0]   operand_value;

  modport source (output valid, output operation, output operand_value, input ready);
  modport sink   (input valid, input operation, input operand_value, output ready);
endinterface

interface lifostk_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [lifostk_pkg::STATUS_W-1:0]        status;
  logic signed [lifostk_pkg::DATA_W-1:0]   popped_value;
  logic                                    key_found;
  logic signed [lifostk_pkg::DATA_W-1:0]   max_value;
  logic signed [lifostk_pkg::DATA_W-1:0]   min_value;
  logic [lifostk_pkg::FILL_W-1:0]          fill_count;

  modport source (output valid, output status, output popped_value, output key_found,
                  output max_value, output min_value, output fill_count, input ready);
  modport sink   (input valid, input status, input popped_value, input key_found,
                  input max_value, input min_value, input fill_count, output ready);
endinterface

>>> rtl/lifostk_ram.sv
// ----------------------------------------------------------------------------
// lifostk_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lifostk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/lifostk_scan.sv
// ----------------------------------------------------------------------------
// lifostk_scan
// shared compare unit: running max, min and key match over streamed entries
// ----------------------------------------------------------------------------
module lifostk_scan (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lifostk_pkg::scan_ctl_t                ctl,
  input  logic signed [lifostk_pkg::DATA_W-1:0] data,
  input  logic signed [lifostk_pkg::DATA_W-1:0] key,
  output lifostk_pkg::scan_res_t                res
);

  logic                                  have_r, have_nxt;
  logic signed [lifostk_pkg::DATA_W-1:0] max_r, max_nxt;
  logic signed [lifostk_pkg::DATA_W-1:0] min_r, min_nxt;
  logic                                  found_r, found_nxt;

  always_comb begin
    have_nxt  = have_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    found_nxt = found_r;
    if (ctl.init) begin
      have_nxt  = 1'b0;
      found_nxt = 1'b0;
    end else if (ctl.step) begin
      have_nxt = 1'b1;
      if (!have_r || data > max_r) begin
        max_nxt = data;
      end
      if (!have_r || data < min_r) begin
        min_nxt = data;
      end
      if (data == key) begin
        found_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      have_r  <= have_nxt;
      found_r <= found_nxt;
    end
    max_r <= max_nxt;
    min_r <= min_nxt;
  end

  assign res.max_val = max_r;
  assign res.min_val = min_r;
  assign res.found   = found_r;

endmodule

>>> rtl/lifo_stack_with_min_max_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_min_max_search
// bounded lifo of signed words with max/min report and key search
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one operation per transfer: push operand_value, pop the
//   top entry, or search for operand_value among all held entries.
//   out_ch returns exactly one result per operation: status, popped value,
//   key match flag, max and min of the contents afterwards, fill count.
// operation sequence:
//   the item is taken in idle and applied in exec; in scan the sequencer
//   walks every held entry once through the single ram read port and the
//   shared compare unit, and done loads the result register. a new item
//   is taken only after the block has returned to idle.
// reset:
//   synchronous active-low reset empties the stack and drops any pending
//   result; ram contents are left as they are and never read unwritten.
// stall:
//   the result waits in the output register; the block finishes the next
//   item and then holds it until the output register is free.
// ----------------------------------------------------------------------------
module lifo_stack_with_min_max_search #(
  parameter int STACK_DEPTH = lifostk_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lifostk_in_if.sink           in_ch,
  lifostk_out_if.source        out_ch
);

  localparam int CW = $clog2(STACK_DEPTH + 1);  // count 0..depth
  localparam int AW = $clog2(STACK_DEPTH);      // ram address
  localparam int DW = lifostk_pkg::DATA_W;

  // sequencer state and item registers
  lifostk_pkg::state_t     state_r, state_nxt;
  logic [lifostk_pkg::OP_W-1:0] op_r, op_nxt;
  logic signed [DW-1:0]    key_r, key_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           cnt_dec;
  lifostk_pkg::status_t    status_r, status_nxt;
  logic signed [DW-1:0]    popped_r, popped_nxt;
  logic                    rd_pop_r, rd_pop_nxt;    // read in flight is the popped entry
  logic                    rd_scan_r, rd_scan_nxt;  // read in flight feeds the compare unit

  // ram port
  logic                    wr_en;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [DW-1:0]           rd_data;

  // compare unit
  lifostk_pkg::scan_ctl_t  scan_ctl;
  lifostk_pkg::scan_res_t  scan_res;

  // output register
  logic                    out_load;
  logic                    out_valid_r;
  logic [lifostk_pkg::STATUS_W-1:0] out_status_r;
  logic signed [DW-1:0]    out_popped_r;
  logic                    out_found_r;
  logic signed [DW-1:0]    out_max_r;
  logic signed [DW-1:0]    out_min_r;
  logic [lifostk_pkg::FILL_W-1:0] out_fill_r;

  assign cnt_dec = cnt_r - CW'(1);

  lifostk_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lifostk_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .data  (rd_data),
    .key   (key_r),
    .res   (scan_res)
  );

  // sequencer: next state and datapath controls
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    status_nxt  = status_r;
    popped_nxt  = popped_r;
    rd_pop_nxt  = 1'b0;
    rd_scan_nxt = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    scan_ctl    = '0;
    out_load    = 1'b0;

    unique case (state_r)
      lifostk_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          key_nxt   = in_ch.operand_value;
          state_nxt = lifostk_pkg::S_EXEC;
        end
      end

      lifostk_pkg::S_EXEC: begin
        // apply the operation, then start the walk over the new contents
        status_nxt    = lifostk_pkg::ST_OK;
        popped_nxt    = '0;
        idx_nxt       = '0;
        scan_ctl.init = 1'b1;
        state_nxt     = lifostk_pkg::S_SCAN;
        unique case (op_r)
          lifostk_pkg::OP_PUSH: begin
            if (cnt_r == CW'(STACK_DEPTH)) begin
              status_nxt = lifostk_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          lifostk_pkg::OP_POP: begin
            if (cnt_r == '0) begin
              status_nxt = lifostk_pkg::ST_EMPTY;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = cnt_dec[AW-1:0];
              cnt_nxt    = cnt_dec;
              rd_pop_nxt = 1'b1;
            end
          end
          lifostk_pkg::OP_SEARCH: begin
            if (cnt_r == '0) begin
              status_nxt = lifostk_pkg::ST_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end

      lifostk_pkg::S_SCAN: begin
        if (rd_pop_r) begin
          popped_nxt = rd_data;
        end
        scan_ctl.step = rd_scan_r;
        if (idx_r < cnt_r) begin
          rd_en       = 1'b1;
          rd_addr     = idx_r[AW-1:0];
          idx_nxt     = idx_r + CW'(1);
          rd_scan_nxt = 1'b1;
        end else if (!rd_scan_r) begin
          state_nxt = lifostk_pkg::S_DONE;
        end
      end

      lifostk_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = lifostk_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lifostk_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lifostk_pkg::S_IDLE;
      cnt_r     <= '0;
      idx_r     <= '0;
      rd_pop_r  <= 1'b0;
      rd_scan_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      rd_pop_r  <= rd_pop_nxt;
      rd_scan_r <= rd_scan_nxt;
    end
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    popped_r <= popped_nxt;
  end

  // output register: loaded once per item, cleared on the result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_popped_r <= popped_r;
      out_found_r  <= scan_res.found && (op_r == lifostk_pkg::OP_SEARCH);
      // empty stack reports zero extremes
      out_max_r    <= (cnt_r == '0) ? '0 : scan_res.max_val;
      out_min_r    <= (cnt_r == '0) ? '0 : scan_res.min_val;
      out_fill_r   <= lifostk_pkg::FILL_W'(cnt_r);
    end
  end

  assign in_ch.ready         = (state_r == lifostk_pkg::S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.popped_value = out_popped_r;
  assign out_ch.key_found    = out_found_r;
  assign out_ch.max_value    = out_max_r;
  assign out_ch.min_value    = out_min_r;
  assign out_ch.fill_count   = out_fill_r;

  // fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("fill count above stack depth");

  // an accepted operation is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == lifostk_pkg::S_EXEC))
    else $error("accepted item not executed");

  // a push into a non-full stack grows it by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lifostk_pkg::S_EXEC && op_r == lifostk_pkg::OP_PUSH &&
     cnt_r != CW'(STACK_DEPTH)) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("push did not grow the stack");

  // the compare unit only steps during the walk
  a_step_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_ctl.step |-> (state_r == lifostk_pkg::S_SCAN))
    else $error("compare step outside walk");

  // a result is only loaded when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("pending result overwritten");

endmodule

>>> tb/sv/lifo_stack_with_min_max_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_min_max_search_tb
// self-checking bench for the lifo stack with min/max report and key search.
// a driver feeds push, pop, search and unused-code transfers from a queue of pending
// operations; a shadow stack predicts every result, and a monitor compares
// each result transfer field by field with the oldest prediction. both
// channels idle at random; once the result side holds off for a long
// stretch so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module lifo_stack_with_min_max_search_tb;

  // unused operation code, the block must leave the stack alone
  localparam logic [lifostk_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int DEPTH        = lifostk_pkg::STACK_DEPTH_DEF;
  localparam int RANDOM_OPS   = 550;
  localparam int HOLD_AFTER   = 300;   // input transfers before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FIRST   = 2000;  // cycle window with no idling on either side
  localparam int CALM_LAST    = 5000;
  localparam int DRAIN_CYCLES = 80;    // full stack scan plus margin

  typedef struct {
    logic [lifostk_pkg::OP_W-1:0]          op;
    logic signed [lifostk_pkg::DATA_W-1:0] operand;
  } stack_op_t;

  typedef struct {
    lifostk_pkg::status_t                  status;
    logic signed [lifostk_pkg::DATA_W-1:0] popped;
    logic                                  found;
    logic signed [lifostk_pkg::DATA_W-1:0] max_v;
    logic signed [lifostk_pkg::DATA_W-1:0] min_v;
    logic [lifostk_pkg::FILL_W-1:0]        fill;
  } stack_result_t;

  logic clk;
  logic rst_n;

  lifostk_in_if  op_bus ();
  lifostk_out_if res_bus ();

  lifo_stack_with_min_max_search i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (op_bus.sink),
    .out_ch (res_bus.source)
  );

  // pending operations, shadow stack and predicted results
  stack_op_t                             pending_ops[$];
  logic signed [lifostk_pkg::DATA_W-1:0] pushed_pool[$];  // every value ever queued for push
  logic signed [lifostk_pkg::DATA_W-1:0] stack_image[$];  // index 0 is the bottom entry
  stack_result_t                         expected_results[$];

  int error_count;
  int ops_taken;
  int cycle_no;
  int hold_left;
  bit hold_done;
  bit calm;

  // --------------------------------------------------------------------------
  // clock, free running from time zero
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // mismatch reporting: one line each, counted
  // --------------------------------------------------------------------------
  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // prediction: apply one operation to the shadow stack, then record the
  // status, popped value, search hit, extremes and fill count it leaves
  // --------------------------------------------------------------------------
  task automatic predict_stack_op(input logic [lifostk_pkg::OP_W-1:0] op,
                                  input logic signed [lifostk_pkg::DATA_W-1:0] operand);
    stack_result_t r;
    r.status = lifostk_pkg::ST_OK;
    r.popped = '0;
    r.found  = 1'b0;
    case (op)
      lifostk_pkg::OP_PUSH: begin
        // a push to a full stack is dropped
        if (stack_image.size() >= DEPTH) r.status = lifostk_pkg::ST_FULL;
        else stack_image.push_back(operand);
      end
      lifostk_pkg::OP_POP: begin
        if (stack_image.size() == 0) r.status = lifostk_pkg::ST_EMPTY;
        else r.popped = stack_image.pop_back();
      end
      lifostk_pkg::OP_SEARCH: begin
        if (stack_image.size() == 0) r.status = lifostk_pkg::ST_EMPTY;
        else begin
          foreach (stack_image[i]) begin
            if (stack_image[i] == operand) r.found = 1'b1;
          end
        end
      end
      default: ;  // unused code: nothing changes, flags stay low
    endcase
    // extremes over what is left, zero when empty
    r.max_v = '0;
    r.min_v = '0;
    foreach (stack_image[i]) begin
      if (i == 0 || stack_image[i] > r.max_v) r.max_v = stack_image[i];
      if (i == 0 || stack_image[i] < r.min_v) r.min_v = stack_image[i];
    end
    r.fill = lifostk_pkg::FILL_W'(stack_image.size());
    expected_results.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_op(input logic [lifostk_pkg::OP_W-1:0] op,
                          input logic signed [lifostk_pkg::DATA_W-1:0] v);
    stack_op_t item;
    item.op      = op;
    item.operand = v;
    pending_ops.push_back(item);
    if (op == lifostk_pkg::OP_PUSH) pushed_pool.push_back(v);
  endtask

  // mix of full-range words, extremes and a narrow band that repeats often
  function automatic logic signed [lifostk_pkg::DATA_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $signed($urandom_range(0, 16)) - 8;
      default: return $signed($urandom());
    endcase
  endfunction

  // search keys mostly hit something pushed earlier, whether still held or not
  function automatic logic signed [lifostk_pkg::DATA_W-1:0] pick_key();
    if (pushed_pool.size() != 0 && $urandom_range(0, 99) < 60) begin
      return pushed_pool[$urandom_range(0, pushed_pool.size() - 1)];
    end
    return pick_word();
  endfunction

  // one burst of operations with given push / pop percentages, rest search,
  // and a sprinkle of the unused code as noise
  task automatic queue_burst(input int n, input int push_pct, input int pop_pct);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) queue_op(lifostk_pkg::OP_PUSH, pick_word());
      else if (roll < push_pct + pop_pct) queue_op(lifostk_pkg::OP_POP, pick_word());
      else if (roll < 98) queue_op(lifostk_pkg::OP_SEARCH, pick_key());
      else queue_op(OP_UNUSED, pick_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // input driver: predicts at each accepted transfer, then offers the next
  // pending operation unless it idles this cycle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    stack_op_t item;
    bit        go;
    if (!rst_n) begin
      op_bus.valid         <= 1'b0;
      op_bus.operation     <= lifostk_pkg::OP_PUSH;
      op_bus.operand_value <= '0;
    end else begin
      if (op_bus.valid && op_bus.ready) begin
        predict_stack_op(op_bus.operation, op_bus.operand_value);
        ops_taken++;
      end
      // a new operation may go out once the current one is taken or none is up
      if (!op_bus.valid || op_bus.ready) begin
        go = calm || ($urandom_range(0, 99) >= 21);
        if (go && pending_ops.size() != 0) begin
          item = pending_ops.pop_front();
          op_bus.valid         <= 1'b1;
          op_bus.operation     <= item.op;
          op_bus.operand_value <= item.operand;
        end else begin
          op_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // cycle count, quiet window and the one long hold-off on the result side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_no  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      calm      <= 1'b0;
    end else begin
      cycle_no <= cycle_no + 1;
      calm     <= (cycle_no >= CALM_FIRST) && (cycle_no < CALM_LAST);
      if (!hold_done && ops_taken >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: every accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_results.size() == 0) begin
          report("result transfer with no operation outstanding");
        end else begin
          want = expected_results.pop_front();
          if (res_bus.status !== want.status)
            report($sformatf("status %0d, predicted %s", res_bus.status, want.status.name()));
          if (res_bus.popped_value !== want.popped)
            report($sformatf("popped_value %0d, predicted %0d",
                             res_bus.popped_value, want.popped));
          if (res_bus.key_found !== want.found)
            report($sformatf("key_found %b, predicted %b", res_bus.key_found, want.found));
          if (res_bus.max_value !== want.max_v)
            report($sformatf("max_value %0d, predicted %0d", res_bus.max_value, want.max_v));
          if (res_bus.min_value !== want.min_v)
            report($sformatf("min_value %0d, predicted %0d", res_bus.min_value, want.min_v));
          if (res_bus.fill_count !== want.fill)
            report($sformatf("fill_count %0d, predicted %0d", res_bus.fill_count, want.fill));
        end
      end
      res_bus.ready <= (hold_left == 0) && (calm || ($urandom_range(0, 99) >= 21));
    end
  end

  // --------------------------------------------------------------------------
  // stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;

    // directed: empty-stack corner cases, word extremes, hits and misses
    queue_op(lifostk_pkg::OP_POP,    32'sd0);          // underflow on empty pop
    queue_op(lifostk_pkg::OP_SEARCH, 32'sd0);          // search of empty stack
    queue_op(OP_UNUSED,              32'sd5);          // unused code on empty stack
    queue_op(lifostk_pkg::OP_PUSH,   32'sh7FFF_FFFF);
    queue_op(lifostk_pkg::OP_PUSH,   32'sh8000_0000);
    queue_op(lifostk_pkg::OP_SEARCH, 32'sh8000_0000);  // hit on the top entry
    queue_op(lifostk_pkg::OP_SEARCH, 32'sh7FFF_FFFE);  // near miss
    queue_op(lifostk_pkg::OP_PUSH,   -32'sd1);
    queue_op(lifostk_pkg::OP_PUSH,   32'sd0);
    queue_op(lifostk_pkg::OP_PUSH,   32'sd1);
    queue_op(OP_UNUSED,              -32'sd1);         // unused code with entries held
    queue_op(lifostk_pkg::OP_SEARCH, 32'sd0);
    queue_op(lifostk_pkg::OP_SEARCH, 32'sh7FFF_FFFF);  // hit on the bottom entry
    queue_op(lifostk_pkg::OP_POP,    32'sd0);
    queue_op(lifostk_pkg::OP_PUSH,   32'sh5555_5555);
    queue_op(lifostk_pkg::OP_PUSH,   32'shAAAA_AAAA);
    queue_op(lifostk_pkg::OP_SEARCH, 32'shAAAA_AAAA);
    for (int k = 0; k < 6; k++) queue_op(lifostk_pkg::OP_POP, 32'sd0);  // drain to empty
    queue_op(lifostk_pkg::OP_POP,    32'sd0);          // underflow again after draining
    queue_op(lifostk_pkg::OP_SEARCH, -32'sd1);         // stale value, stack empty

    // random: fill past full, drain past empty, then mixed bursts
    queue_burst(80, 88, 0);
    queue_burst(80, 0, 88);
    while (pending_ops.size() < RANDOM_OPS + 25) begin
      case ($urandom_range(0, 2))
        0:       queue_burst($urandom_range(60, 75), 85, 5);
        1:       queue_burst($urandom_range(60, 75), 5, 85);
        default: queue_burst($urandom_range(20, 40), 45, 40);
      endcase
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // all operations taken, all results back, then a scan's worth of quiet
    while (pending_ops.size() != 0 || op_bus.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
